/* hw/rtl/ssu_pkg.sv */
// ----------------------------------------------------------------------------
// ssu_pkg: shared constants for the stream summary statistics unit
// Fixed field widths of the result beat that do not follow the sample width.
// ----------------------------------------------------------------------------
package ssu_pkg;

  // Sample positions are reported modulo 2^16.
  localparam int unsigned POS_W = 16;
  // The reported sample count is 17 bits wide.
  localparam int unsigned CNT_W = 17;

endpackage

/* hw/rtl/ssu_in_if.sv */
// ----------------------------------------------------------------------------
// ssu_in_if: sample stream channel
// Carries one signed sample per beat and a flag on the last sample of a block.
// ----------------------------------------------------------------------------
interface ssu_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);

endinterface

/* hw/rtl/ssu_out_if.sv */
// ----------------------------------------------------------------------------
// ssu_out_if: block statistics channel
// Carries the summary of one finished block per beat.
// ----------------------------------------------------------------------------
interface ssu_out_if import ssu_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
);

  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_BITS-1:0]   mean_value;
  logic        [SAMPLE_BITS-1:0]   mean_abs;
  logic        [2*SAMPLE_BITS-2:0] mean_square;
  logic        [SAMPLE_BITS-1:0]   root_mean_square;
  logic        [SAMPLE_BITS-1:0]   std_dev;
  logic signed [SAMPLE_BITS-1:0]   min_value;
  logic signed [SAMPLE_BITS-1:0]   max_value;
  logic        [POS_W-1:0]         min_position;
  logic        [POS_W-1:0]         max_position;
  logic        [CNT_W-1:0]         sample_count;
  logic                            overflow;

  modport source (
    output valid, output mean_value, output mean_abs, output mean_square,
    output root_mean_square, output std_dev, output min_value, output max_value,
    output min_position, output max_position, output sample_count, output overflow,
    input ready
  );
  modport sink (
    input valid, input mean_value, input mean_abs, input mean_square,
    input root_mean_square, input std_dev, input min_value, input max_value,
    input min_position, input max_position, input sample_count, input overflow,
    output ready
  );

endinterface

/* hw/rtl/stream_summary_statistics_unit.sv */
// ----------------------------------------------------------------------------
// stream_summary_statistics_unit: block mean, RMS, deviation, min and max
// Accumulates a block of samples and, after the last one, derives the
// statistics with one shared add/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
//  Channel  Modport  Beat carries
//  in_i     sink     sample, last
//  out_o    source   mean, mean abs, mean square, RMS, std dev, min/max, count
//
//  A sample that is not last is accepted back to back while in_i.ready is high.
//  A last sample is accumulated and then starts the sequencer, which derives
//  the statistics by shifts and adds in the shared unit; meanwhile in_i.ready
//  is low. The finished beat waits in the output register, so the next
//  block is accepted while it is still pending; if that block finishes
//  first, the final step holds until the pending beat is taken.
//  Reset clears the accumulators and the sequencer; no clearing pass is needed.
module stream_summary_statistics_unit import ssu_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 65536,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssu_in_if.sink    in_i,
  ssu_out_if.source out_o
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned CW    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUMW  = SB + CW;
  localparam int unsigned MAGW  = SB + CW - 1;
  localparam int unsigned ABSW  = SB + CW - 1;
  localparam int unsigned SQW   = 2 * SB + CW - 2;
  localparam int unsigned DW    = 2 * SB + 2 * CW - 2;
  localparam int unsigned STW   = $clog2(DW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_NN,     // n * n into the divisor
    S_NS,     // acc = n * sum of squares
    S_SS,     // acc -= |sum|^2
    S_DVAR,   // variance = acc / n^2
    S_SVAR,   // std dev = sqrt(variance)
    S_DMEAN,
    S_DABS,
    S_DMSQ,
    S_SRMS,
    S_OUT
  } state_e;

  state_e                 state_q;
  logic [STW-1:0]         step_q;

  // Accumulators
  logic [CW-1:0]          cnt_q;
  logic signed [SUMW-1:0] sum_q;
  logic [ABSW-1:0]        abs_q;
  logic [SQW-1:0]         sq_q;
  logic signed [SB-1:0]   min_q;
  logic signed [SB-1:0]   max_q;
  logic [POS_W-1:0]       min_pos_q;
  logic [POS_W-1:0]       max_pos_q;
  logic                   drop_q;

  // Shared unit operands and scratch results
  logic [DW-1:0]          acc_q;
  logic [DW-1:0]          opa_q;
  logic [DW-1:0]          opb_q;
  logic [DW-1:0]          dvs_q;
  logic [SB-1:0]          mean_q;
  logic [SB-1:0]          mabs_q;
  logic [2*SB-2:0]        msq_q;
  logic [SB-1:0]          sd_q;
  logic [SB-1:0]          rms_q;

  // Output register
  logic                   out_valid_q;
  logic [SB-1:0]          o_mean_q;
  logic [SB-1:0]          o_mabs_q;
  logic [2*SB-2:0]        o_msq_q;
  logic [SB-1:0]          o_rms_q;
  logic [SB-1:0]          o_sd_q;
  logic [SB-1:0]          o_min_q;
  logic [SB-1:0]          o_max_q;
  logic [POS_W-1:0]       o_min_pos_q;
  logic [POS_W-1:0]       o_max_pos_q;
  logic [CNT_W-1:0]       o_cnt_q;
  logic                   o_ovf_q;

  logic                   in_fire;
  logic [SB-1:0]          x_bits;
  logic [SB-1:0]          x_mag;
  logic [2*SB-1:0]        x_sq;
  logic                   first_smp;
  logic                   room;
  logic [CW+POS_W-1:0]    pos_ext;
  logic [CW+CNT_W-1:0]    cnt_ext;
  logic                   sum_neg;
  logic [SUMW-1:0]        sum_abs;
  logic [MAGW-1:0]        smag;

  logic [DW-1:0]          unit_a;
  logic [DW-1:0]          unit_b;
  logic                   unit_sub;
  logic [DW:0]            unit_res;
  logic                   take;
  logic [DW-1:0]          quot_nx;
  logic [DW-1:0]          root_nx;
  logic [DW-1:0]          rem_nx;
  logic                   last_step;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  assign x_bits    = in_i.sample;
  assign x_mag     = x_bits[SB-1] ? (~x_bits + SB'(1)) : x_bits;
  assign x_sq      = x_mag * x_mag;
  assign first_smp = (cnt_q == '0);
  assign room      = (cnt_q < CW'(MAX_SAMPLES));
  assign pos_ext   = {{POS_W{1'b0}}, cnt_q};
  assign cnt_ext   = {{CNT_W{1'b0}}, cnt_q};

  assign sum_neg = sum_q[SUMW-1];
  assign sum_abs = sum_neg ? (SUMW'(0) - sum_q) : sum_q;
  assign smag    = sum_abs[MAGW-1:0];

  // Shared add/subtract unit. For subtraction the top bit is the borrow.
  always_comb begin
    unit_a   = acc_q;
    unit_b   = '0;
    unit_sub = 1'b0;
    unique case (state_q)
      S_NN, S_NS: begin
        unit_b = opb_q[0] ? opa_q : '0;
      end
      S_SS: begin
        unit_b   = opb_q[0] ? opa_q : '0;
        unit_sub = 1'b1;
      end
      S_DVAR, S_DMEAN, S_DABS, S_DMSQ: begin
        unit_a   = {acc_q[DW-2:0], opa_q[DW-1]};
        unit_b   = dvs_q;
        unit_sub = 1'b1;
      end
      S_SVAR, S_SRMS: begin
        unit_a   = {acc_q[DW-3:0], opa_q[DW-1:DW-2]};
        unit_b   = {opb_q[DW-3:0], 2'b01};
        unit_sub = 1'b1;
      end
      default: begin
      end
    endcase
    unit_res = {1'b0, unit_a} + ({1'b0, unit_b} ^ {(DW+1){unit_sub}})
             + (DW+1)'(unit_sub);
  end

  assign take      = ~unit_res[DW];
  assign rem_nx    = take ? unit_res[DW-1:0] : unit_a;
  assign quot_nx   = {opa_q[DW-2:0], take};
  assign root_nx   = {opb_q[DW-2:0], take};
  assign last_step = (step_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      abs_q       <= '0;
      sq_q        <= '0;
      min_q       <= '0;
      max_q       <= '0;
      min_pos_q   <= '0;
      max_pos_q   <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q != S_IDLE && state_q != S_OUT && !last_step) begin
        step_q <= step_q - STW'(1);
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (room) begin
              if (first_smp || (in_i.sample < min_q)) begin
                min_q     <= in_i.sample;
                min_pos_q <= pos_ext[POS_W-1:0];
              end
              if (first_smp || (in_i.sample > max_q)) begin
                max_q     <= in_i.sample;
                max_pos_q <= pos_ext[POS_W-1:0];
              end
              sum_q <= sum_q + {{(SUMW-SB){x_bits[SB-1]}}, x_bits};
              abs_q <= abs_q + {{(ABSW-SB){1'b0}}, x_mag};
              sq_q  <= sq_q + {{(SQW-2*SB){1'b0}}, x_sq};
              cnt_q <= cnt_q + CW'(1);
            end else begin
              drop_q <= 1'b1;
            end
            if (in_i.last) begin
              // The count used below already includes this sample.
              acc_q   <= '0;
              opa_q   <= DW'(room ? cnt_q + CW'(1) : cnt_q);
              opb_q   <= DW'(room ? cnt_q + CW'(1) : cnt_q);
              step_q  <= STW'(CW - 1);
              state_q <= S_NN;
            end
          end
        end

        S_NN, S_NS, S_SS: begin
          acc_q <= unit_res[DW-1:0];
          opa_q <= {opa_q[DW-2:0], 1'b0};
          opb_q <= {1'b0, opb_q[DW-1:1]};
          if (last_step) begin
            if (state_q == S_NN) begin
              dvs_q   <= unit_res[DW-1:0];
              acc_q   <= '0;
              opa_q   <= DW'(sq_q);
              opb_q   <= DW'(cnt_q);
              step_q  <= STW'(CW - 1);
              state_q <= S_NS;
            end else if (state_q == S_NS) begin
              opa_q   <= DW'(smag);
              opb_q   <= DW'(smag);
              step_q  <= STW'(MAGW - 1);
              state_q <= S_SS;
            end else begin
              // n * sumsq - sum^2 is never negative, so no clamp is needed.
              acc_q   <= '0;
              opa_q   <= unit_res[DW-1:0];
              step_q  <= STW'(DW - 1);
              state_q <= S_DVAR;
            end
          end
        end

        S_DVAR, S_DMEAN, S_DABS, S_DMSQ: begin
          acc_q <= rem_nx;
          opa_q <= quot_nx;
          if (last_step) begin
            acc_q <= '0;
            unique case (state_q)
              S_DVAR: begin
                opa_q   <= {quot_nx[2*SB-1:0], {(DW-2*SB){1'b0}}};
                opb_q   <= '0;
                step_q  <= STW'(SB - 1);
                state_q <= S_SVAR;
              end
              S_DMEAN: begin
                mean_q  <= sum_neg ? (SB'(0) - quot_nx[SB-1:0]) : quot_nx[SB-1:0];
                opa_q   <= {abs_q, {(DW-ABSW){1'b0}}};
                step_q  <= STW'(ABSW - 1);
                state_q <= S_DABS;
              end
              S_DABS: begin
                mabs_q  <= quot_nx[SB-1:0];
                opa_q   <= {sq_q, {(DW-SQW){1'b0}}};
                step_q  <= STW'(SQW - 1);
                state_q <= S_DMSQ;
              end
              default: begin
                msq_q   <= quot_nx[2*SB-2:0];
                opa_q   <= {1'b0, quot_nx[2*SB-2:0], {(DW-2*SB){1'b0}}};
                opb_q   <= '0;
                step_q  <= STW'(SB - 1);
                state_q <= S_SRMS;
              end
            endcase
          end
        end

        S_SVAR, S_SRMS: begin
          acc_q <= rem_nx;
          opa_q <= {opa_q[DW-3:0], 2'b00};
          opb_q <= root_nx;
          if (last_step) begin
            if (state_q == S_SVAR) begin
              sd_q    <= root_nx[SB-1:0];
              acc_q   <= '0;
              opa_q   <= {smag, {(DW-MAGW){1'b0}}};
              dvs_q   <= DW'(cnt_q);
              step_q  <= STW'(MAGW - 1);
              state_q <= S_DMEAN;
            end else begin
              rms_q   <= root_nx[SB-1:0];
              state_q <= S_OUT;
            end
          end
        end

        S_OUT: begin
          // Wait here while the previous block's beat is still unclaimed.
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            o_mean_q    <= mean_q;
            o_mabs_q    <= mabs_q;
            o_msq_q     <= msq_q;
            o_rms_q     <= rms_q;
            o_sd_q      <= sd_q;
            o_min_q     <= min_q;
            o_max_q     <= max_q;
            o_min_pos_q <= min_pos_q;
            o_max_pos_q <= max_pos_q;
            o_cnt_q     <= cnt_ext[CNT_W-1:0];
            o_ovf_q     <= drop_q;
            cnt_q       <= '0;
            sum_q       <= '0;
            abs_q       <= '0;
            sq_q        <= '0;
            min_q       <= '0;
            max_q       <= '0;
            min_pos_q   <= '0;
            max_pos_q   <= '0;
            drop_q      <= 1'b0;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.mean_value       = o_mean_q;
  assign out_o.mean_abs         = o_mabs_q;
  assign out_o.mean_square      = o_msq_q;
  assign out_o.root_mean_square = o_rms_q;
  assign out_o.std_dev          = o_sd_q;
  assign out_o.min_value        = o_min_q;
  assign out_o.max_value        = o_max_q;
  assign out_o.min_position     = o_min_pos_q;
  assign out_o.max_position     = o_max_pos_q;
  assign out_o.sample_count     = o_cnt_q;
  assign out_o.overflow         = o_ovf_q;

  // A last sample always starts the sequencer, so the next cycle is busy.
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.last) |=> !in_i.ready)
    else $error("input still ready after a last sample");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_SAMPLES))
    else $error("sample count beyond the maximum");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_q <= max_q))
    else $error("running minimum above running maximum");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result beat raised outside the final step");

  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (step_q == '0))
    else $error("step counter not cleared in idle");

endmodule
